>>> rtl/two_port_terminated_impedance_assert.svh
// Assertion macros shared by the impedance pipeline.
`ifndef TWO_PORT_TERMINATED_IMPEDANCE_ASSERT_SVH
`define TWO_PORT_TERMINATED_IMPEDANCE_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define TPTI_ASSERT_IMP(lbl, clk_i, rstn_i, ante, cons) \
	lbl: assert property (@(posedge clk_i) disable iff (!rstn_i) (ante) |-> (cons)) \
		else $error("two_port_terminated_impedance: same-cycle check failed");

// Next-cycle implication, checked outside reset.
`define TPTI_ASSERT_NEXT(lbl, clk_i, rstn_i, ante, cons) \
	lbl: assert property (@(posedge clk_i) disable iff (!rstn_i) (ante) |=> (cons)) \
		else $error("two_port_terminated_impedance: next-cycle check failed");

`endif

>>> rtl/tpti_pkg.sv
`timescale 1ns / 1ps
package tpti_pkg;

	localparam int DATA_WIDTH_DEF = 32;
	localparam int FRAC_BITS_DEF  = 16;

	// Limb width of the split multipliers and their fixed latency.
	localparam int LIMB_W  = 32;
	localparam int MUL_LAT = 3;

	typedef logic [1:0] status_t;

	localparam status_t STATUS_OK       = 2'd0;
	localparam status_t STATUS_DIV_ZERO = 2'd1;
	localparam status_t STATUS_SAT      = 2'd2;

	function automatic int max2(input int a, input int b);
		return (a > b) ? a : b;
	endfunction

endpackage

>>> rtl/two_port_terminated_impedance.sv
`timescale 1ns / 1ps
// Channel  | handshake                   | payload
// item     | item_valid / item_stall     | operation, a..d real/imag, term_real/imag
// result   | result_valid / result_stall | impedance_real, impedance_imag, status
//
// One item enters every cycle while item_stall is low; the latency is set by
// the two split multiplier banks and the bit-per-stage divider that needs
// DATA_WIDTH + 1 quotient stages.
// Reset clears only the valid bits; data registers start undefined.
// A result that waits under result_stall freezes every stage, so item_stall is
// high exactly while the last stage holds a result that is being stalled.
`include "two_port_terminated_impedance_assert.svh"

module two_port_terminated_impedance import tpti_pkg::*; #(
	parameter int DATA_WIDTH = DATA_WIDTH_DEF,
	parameter int FRAC_BITS  = FRAC_BITS_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         item_valid,
	output logic                         item_stall,
	input  logic                         operation,
	input  logic signed [DATA_WIDTH-1:0] a_real,
	input  logic signed [DATA_WIDTH-1:0] a_imag,
	input  logic signed [DATA_WIDTH-1:0] b_real,
	input  logic signed [DATA_WIDTH-1:0] b_imag,
	input  logic signed [DATA_WIDTH-1:0] c_real,
	input  logic signed [DATA_WIDTH-1:0] c_imag,
	input  logic signed [DATA_WIDTH-1:0] d_real,
	input  logic signed [DATA_WIDTH-1:0] d_imag,
	input  logic signed [DATA_WIDTH-1:0] term_real,
	input  logic signed [DATA_WIDTH-1:0] term_imag,
	output logic                         result_valid,
	input  logic                         result_stall,
	output logic signed [DATA_WIDTH-1:0] impedance_real,
	output logic signed [DATA_WIDTH-1:0] impedance_imag,
	output status_t                      status
);
	// Numerator and denominator parts are kept at scale 2^(2F); NW holds them
	// exactly. Their products give the quotient operands at scale 2^(4F).
	localparam int NW     = max2(2 * DATA_WIDTH, DATA_WIDTH + FRAC_BITS) + 2;
	localparam int PW     = 2 * DATA_WIDTH;
	localparam int MW     = 2 * NW;
	localparam int RW     = MW + 1;
	localparam int XW     = RW + FRAC_BITS;
	localparam int DIVLAT = DATA_WIDTH + 3;
	localparam int LAT    = 1 + MUL_LAT + 1 + MUL_LAT + 1 + DIVLAT + 1;

	logic en;
	logic vld_s [LAT];

	// Stage one: operands, with the matrix elements picked by the operation.
	logic signed [DATA_WIDTH-1:0] p_r_s1, p_i_s1, c_r_s1, c_i_s1, z_r_s1, z_i_s1;
	logic signed [NW-1:0]         add_s1 [4];
	logic signed [NW-1:0]         add_dl [MUL_LAT][4];

	logic signed [PW-1:0] pr_zr, pi_zi, pr_zi, pi_zr, cr_zr, ci_zi, cr_zi, ci_zr;

	logic signed [NW-1:0] n_r_s5, n_i_s5, e_r_s5, e_i_s5;

	logic signed [MW-1:0] nr_er, ni_ei, ni_er, nr_ei, er_er, ei_ei;

	logic signed [RW-1:0] re_raw, im_raw;
	logic [RW-1:0]        re_abs, im_abs;
	logic [XW-1:0]        x_re_s9, x_im_s9;
	logic                 neg_re_s9, neg_im_s9;
	logic [MW-1:0]        mag2_s9;

	logic                  zero_dl [DIVLAT];
	logic [DATA_WIDTH-1:0] q_re, q_im;
	logic                  sat_re, sat_im;

	logic signed [DATA_WIDTH-1:0] imp_r_q, imp_i_q;
	status_t                      status_q;

	// The whole pipe advances unless the last stage holds a stalled result.
	assign en         = !(vld_s[LAT-1] && result_stall);
	assign item_stall = !en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < LAT; k++) begin
				vld_s[k] <= 1'b0;
			end
		end else if (en) begin
			vld_s[0] <= item_valid;
			for (int k = 1; k < LAT; k++) begin
				vld_s[k] <= vld_s[k-1];
			end
		end
	end

	// Operation 1 swaps A and D: (D*Z + B) / (C*Z + A).
	always_ff @(posedge clk) begin
		if (en) begin
			p_r_s1    <= operation ? d_real : a_real;
			p_i_s1    <= operation ? d_imag : a_imag;
			add_s1[0] <= NW'(b_real) <<< FRAC_BITS;
			add_s1[1] <= NW'(b_imag) <<< FRAC_BITS;
			add_s1[2] <= NW'(operation ? a_real : d_real) <<< FRAC_BITS;
			add_s1[3] <= NW'(operation ? a_imag : d_imag) <<< FRAC_BITS;
			c_r_s1    <= c_real;
			c_i_s1    <= c_imag;
			z_r_s1    <= term_real;
			z_i_s1    <= term_imag;
		end
	end

	// The scaled B and S terms wait beside the first multiplier bank.
	always_ff @(posedge clk) begin
		if (en) begin
			for (int m = 0; m < 4; m++) begin
				add_dl[0][m] <= add_s1[m];
				for (int k = 1; k < MUL_LAT; k++) begin
					add_dl[k][m] <= add_dl[k-1][m];
				end
			end
		end
	end

	tpti_mul #(.A_W(DATA_WIDTH), .B_W(DATA_WIDTH)) u_mul_pr_zr (
		.clk(clk), .en(en), .a(p_r_s1), .b(z_r_s1), .p(pr_zr));
	tpti_mul #(.A_W(DATA_WIDTH), .B_W(DATA_WIDTH)) u_mul_pi_zi (
		.clk(clk), .en(en), .a(p_i_s1), .b(z_i_s1), .p(pi_zi));
	tpti_mul #(.A_W(DATA_WIDTH), .B_W(DATA_WIDTH)) u_mul_pr_zi (
		.clk(clk), .en(en), .a(p_r_s1), .b(z_i_s1), .p(pr_zi));
	tpti_mul #(.A_W(DATA_WIDTH), .B_W(DATA_WIDTH)) u_mul_pi_zr (
		.clk(clk), .en(en), .a(p_i_s1), .b(z_r_s1), .p(pi_zr));
	tpti_mul #(.A_W(DATA_WIDTH), .B_W(DATA_WIDTH)) u_mul_cr_zr (
		.clk(clk), .en(en), .a(c_r_s1), .b(z_r_s1), .p(cr_zr));
	tpti_mul #(.A_W(DATA_WIDTH), .B_W(DATA_WIDTH)) u_mul_ci_zi (
		.clk(clk), .en(en), .a(c_i_s1), .b(z_i_s1), .p(ci_zi));
	tpti_mul #(.A_W(DATA_WIDTH), .B_W(DATA_WIDTH)) u_mul_cr_zi (
		.clk(clk), .en(en), .a(c_r_s1), .b(z_i_s1), .p(cr_zi));
	tpti_mul #(.A_W(DATA_WIDTH), .B_W(DATA_WIDTH)) u_mul_ci_zr (
		.clk(clk), .en(en), .a(c_i_s1), .b(z_r_s1), .p(ci_zr));

	// Numerator N = P*Z + B and denominator E = C*Z + S, exact.
	always_ff @(posedge clk) begin
		if (en) begin
			n_r_s5 <= NW'(pr_zr) - NW'(pi_zi) + add_dl[MUL_LAT-1][0];
			n_i_s5 <= NW'(pr_zi) + NW'(pi_zr) + add_dl[MUL_LAT-1][1];
			e_r_s5 <= NW'(cr_zr) - NW'(ci_zi) + add_dl[MUL_LAT-1][2];
			e_i_s5 <= NW'(cr_zi) + NW'(ci_zr) + add_dl[MUL_LAT-1][3];
		end
	end

	tpti_mul #(.A_W(NW), .B_W(NW)) u_mul_nr_er (
		.clk(clk), .en(en), .a(n_r_s5), .b(e_r_s5), .p(nr_er));
	tpti_mul #(.A_W(NW), .B_W(NW)) u_mul_ni_ei (
		.clk(clk), .en(en), .a(n_i_s5), .b(e_i_s5), .p(ni_ei));
	tpti_mul #(.A_W(NW), .B_W(NW)) u_mul_ni_er (
		.clk(clk), .en(en), .a(n_i_s5), .b(e_r_s5), .p(ni_er));
	tpti_mul #(.A_W(NW), .B_W(NW)) u_mul_nr_ei (
		.clk(clk), .en(en), .a(n_r_s5), .b(e_i_s5), .p(nr_ei));
	tpti_mul #(.A_W(NW), .B_W(NW)) u_mul_er_er (
		.clk(clk), .en(en), .a(e_r_s5), .b(e_r_s5), .p(er_er));
	tpti_mul #(.A_W(NW), .B_W(NW)) u_mul_ei_ei (
		.clk(clk), .en(en), .a(e_i_s5), .b(e_i_s5), .p(ei_ei));

	// N * conj(E) over |E|^2; the real and imaginary parts split into sign
	// and magnitude, with the magnitude lifted by 2^F for the Q format.
	assign re_raw = RW'(nr_er) + RW'(ni_ei);
	assign im_raw = RW'(ni_er) - RW'(nr_ei);
	assign re_abs = re_raw[RW-1] ? RW'(-re_raw) : RW'(re_raw);
	assign im_abs = im_raw[RW-1] ? RW'(-im_raw) : RW'(im_raw);

	always_ff @(posedge clk) begin
		if (en) begin
			x_re_s9   <= XW'(re_abs) << FRAC_BITS;
			x_im_s9   <= XW'(im_abs) << FRAC_BITS;
			neg_re_s9 <= re_raw[RW-1];
			neg_im_s9 <= im_raw[RW-1];
			mag2_s9   <= MW'(er_er + ei_ei);
		end
	end

	// The zero-denominator flag rides beside the dividers.
	always_ff @(posedge clk) begin
		if (en) begin
			zero_dl[0] <= (mag2_s9 == '0);
			for (int k = 1; k < DIVLAT; k++) begin
				zero_dl[k] <= zero_dl[k-1];
			end
		end
	end

	tpti_div #(.DATA_WIDTH(DATA_WIDTH), .X_W(XW), .D_W(MW)) u_div_re (
		.clk(clk), .en(en), .x(x_re_s9), .d(mag2_s9), .neg(neg_re_s9),
		.res(q_re), .sat(sat_re));
	tpti_div #(.DATA_WIDTH(DATA_WIDTH), .X_W(XW), .D_W(MW)) u_div_im (
		.clk(clk), .en(en), .x(x_im_s9), .d(mag2_s9), .neg(neg_im_s9),
		.res(q_im), .sat(sat_im));

	// Output register: a zero denominator forces both parts to zero.
	always_ff @(posedge clk) begin
		if (en) begin
			if (zero_dl[DIVLAT-1]) begin
				imp_r_q  <= '0;
				imp_i_q  <= '0;
				status_q <= STATUS_DIV_ZERO;
			end else begin
				imp_r_q  <= q_re;
				imp_i_q  <= q_im;
				status_q <= (sat_re || sat_im) ? STATUS_SAT : STATUS_OK;
			end
		end
	end

	assign result_valid   = vld_s[LAT-1];
	assign impedance_real = imp_r_q;
	assign impedance_imag = imp_i_q;
	assign status         = status_q;

	`TPTI_ASSERT_IMP(a_stall_follows_out, clk, arst_n, 1'b1, item_stall == (result_valid && result_stall))
	`TPTI_ASSERT_NEXT(a_accept_enters, clk, arst_n, item_valid && !item_stall, vld_s[0])
	`TPTI_ASSERT_IMP(a_zero_den_clears, clk, arst_n, result_valid && status == STATUS_DIV_ZERO, impedance_real == '0 && impedance_imag == '0)

endmodule

>>> rtl/tpti_mul.sv
`timescale 1ns / 1ps
// Signed multiplier split into limb products, three register stages.
module tpti_mul import tpti_pkg::*; #(
	parameter int A_W = 32,
	parameter int B_W = 32
) (
	input  logic                     clk,
	input  logic                     en,
	input  logic signed [A_W-1:0]    a,
	input  logic signed [B_W-1:0]    b,
	output logic signed [A_W+B_W-1:0] p
);
	localparam int NA  = (A_W + LIMB_W - 1) / LIMB_W;
	localparam int NB  = (B_W + LIMB_W - 1) / LIMB_W;
	localparam int AX  = NA * LIMB_W;
	localparam int BX  = NB * LIMB_W;
	localparam int SW  = AX + BX + 2;
	localparam int PPW = 2 * LIMB_W + 2;

	logic signed [AX-1:0]  ax;
	logic signed [BX-1:0]  bx;
	logic signed [PPW-1:0] pp_d [NA][NB];
	logic signed [PPW-1:0] pp_s1 [NA][NB];
	logic signed [SW-1:0]  row_d [NA];
	logic signed [SW-1:0]  row_s2 [NA];
	logic signed [SW-1:0]  prod_d;
	logic signed [SW-1:0]  prod_s3;

	assign ax = AX'(a);
	assign bx = BX'(b);

	// Lower limbs are unsigned, the top limb carries the sign.
	always_comb begin
		logic signed [LIMB_W:0] la;
		logic signed [LIMB_W:0] lb;
		for (int i = 0; i < NA; i++) begin
			for (int j = 0; j < NB; j++) begin
				la = {((i == NA - 1) ? ax[AX-1] : 1'b0), ax[i*LIMB_W +: LIMB_W]};
				lb = {((j == NB - 1) ? bx[BX-1] : 1'b0), bx[j*LIMB_W +: LIMB_W]};
				pp_d[i][j] = la * lb;
			end
		end
	end

	always_comb begin
		for (int i = 0; i < NA; i++) begin
			row_d[i] = '0;
			for (int j = 0; j < NB; j++) begin
				row_d[i] = row_d[i] + (SW'(pp_s1[i][j]) <<< (LIMB_W * j));
			end
		end
	end

	always_comb begin
		prod_d = '0;
		for (int i = 0; i < NA; i++) begin
			prod_d = prod_d + (row_s2[i] <<< (LIMB_W * i));
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < NA; i++) begin
				for (int j = 0; j < NB; j++) begin
					pp_s1[i][j] <= pp_d[i][j];
				end
				row_s2[i] <= row_d[i];
			end
			prod_s3 <= prod_d;
		end
	end

	assign p = prod_s3[A_W+B_W-1:0];

endmodule

>>> rtl/tpti_div.sv
`timescale 1ns / 1ps
// Restoring divider, one quotient bit per stage, with rounding and clamping.
module tpti_div import tpti_pkg::*; #(
	parameter int DATA_WIDTH = DATA_WIDTH_DEF,
	parameter int X_W        = 64,
	parameter int D_W        = 64
) (
	input  logic                  clk,
	input  logic                  en,
	input  logic [X_W-1:0]        x,
	input  logic [D_W-1:0]        d,
	input  logic                  neg,
	output logic [DATA_WIDTH-1:0] res,
	output logic                  sat
);
	localparam int QW = DATA_WIDTH + 1;
	localparam int CW = X_W + QW + 1;

	logic [X_W-1:0] rem_s [0:QW];
	logic [D_W-1:0] den_s [0:QW];
	logic [QW-1:0]  quo_s [0:QW];
	logic           neg_s [0:QW];
	logic           ovf_s [0:QW];

	logic [X_W-1:0] rem_nx [1:QW];
	logic [QW-1:0]  quo_nx [1:QW];
	logic           ovf_d;

	logic [X_W:0]   rem2;
	logic           rnd;
	logic [QW:0]    mag;
	logic [QW:0]    lim;
	logic           over;
	logic [QW:0]    magc;
	logic [QW:0]    sgn;

	logic [DATA_WIDTH-1:0] res_q;
	logic                  sat_q;

	// Quotients of 2^QW or more cannot fit and clamp at once.
	assign ovf_d = CW'(x) >= (CW'(d) << QW);

	always_comb begin
		logic [CW-1:0] shd;
		logic          take;
		for (int t = 1; t <= QW; t++) begin
			shd       = CW'(den_s[t-1]) << (QW - t);
			take      = CW'(rem_s[t-1]) >= shd;
			rem_nx[t] = take ? X_W'(CW'(rem_s[t-1]) - shd) : rem_s[t-1];
			quo_nx[t] = quo_s[t-1] | (take ? (QW'(1) << (QW - t)) : '0);
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rem_s[0] <= x;
			den_s[0] <= d;
			quo_s[0] <= '0;
			neg_s[0] <= neg;
			ovf_s[0] <= ovf_d;
			for (int t = 1; t <= QW; t++) begin
				rem_s[t] <= rem_nx[t];
				den_s[t] <= den_s[t-1];
				quo_s[t] <= quo_nx[t];
				neg_s[t] <= neg_s[t-1];
				ovf_s[t] <= ovf_s[t-1];
			end
		end
	end

	// Round half away from zero on the magnitude, then clamp to the signed range.
	assign rem2 = {rem_s[QW], 1'b0};
	assign rnd  = rem2 >= (X_W + 1)'(den_s[QW]);
	assign mag  = (QW + 1)'(quo_s[QW]) + (QW + 1)'(rnd);
	assign lim  = ((QW + 1)'(1) << (DATA_WIDTH - 1)) - (QW + 1)'(!neg_s[QW]);
	assign over = ovf_s[QW] || (mag > lim);
	assign magc = over ? lim : mag;
	assign sgn  = neg_s[QW] ? ((QW + 1)'(0) - magc) : magc;

	always_ff @(posedge clk) begin
		if (en) begin
			res_q <= sgn[DATA_WIDTH-1:0];
			sat_q <= over;
		end
	end

	assign res = res_q;
	assign sat = sat_q;

endmodule

>>> sim/tb_top.sv
`timescale 1ns / 1ps
module tb_top;
	import tpti_pkg::*;

	localparam int DW = 32;
	localparam int FB = 16;
	// Pipeline depth, used to size the long receiver hold and the final drain.
	localparam int PIPE_DEPTH = 2 * MUL_LAT + DW + 7;
	localparam int N_RANDOM = 1330;

	// Wide signed numbers hold the exact numerator and denominator products.
	typedef logic signed [191:0] wide_t;
	typedef logic [191:0] wmag_t;

	typedef struct {
		logic          op;
		logic [DW-1:0] ar, ai, br, bi, cr, ci, dr, di, zr, zi;
	} network_item_t;

	typedef struct {
		logic [DW-1:0] zre, zim;
		status_t       st;
	} impedance_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic item_valid = 1'b0;
	logic item_stall;
	logic operation = 1'b0;
	logic signed [DW-1:0] a_real = '0, a_imag = '0, b_real = '0, b_imag = '0;
	logic signed [DW-1:0] c_real = '0, c_imag = '0, d_real = '0, d_imag = '0;
	logic signed [DW-1:0] term_real = '0, term_imag = '0;
	logic result_valid;
	logic result_stall = 1'b0;
	logic signed [DW-1:0] impedance_real, impedance_imag;
	status_t status;

	network_item_t pending_items[$];
	impedance_t impedance_due[$];
	int sent_count = 0;
	int hold_cycles = 0;
	bit hold_done = 1'b0;
	bit failed = 1'b0;

	always #5 clk = ~clk;

	two_port_terminated_impedance dut (.*);

	// Rounded quotient of an exact numerator by a positive denominator, with
	// ties going away from zero and the result clamped to the signed word.
	function automatic logic [DW-1:0] rounded_quotient(input wide_t num, input wide_t den,
			inout bit sat);
		wmag_t mag, q, r, limit;
		bit neg;
		neg = (num < 0);
		mag = neg ? wmag_t'(-num) : wmag_t'(num);
		q = mag / wmag_t'(den);
		r = mag % wmag_t'(den);
		if ((r << 1) >= wmag_t'(den))
			q = q + 1;
		limit = neg ? (wmag_t'(1) << (DW - 1)) : ((wmag_t'(1) << (DW - 1)) - 1);
		if (q > limit) begin
			sat = 1'b1;
			q = limit;
		end
		return neg ? DW'(-q) : DW'(q);
	endfunction

	// Input impedance (A*Z+B)/(C*Z+D), or output impedance (D*Z+B)/(C*Z+A),
	// formed exactly at scale 2^(2*FB) before the one final rounding.
	function automatic impedance_t terminated_impedance(input network_item_t it);
		wide_t pr, pi, sr, si, br, bi, cr, ci, zr, zi;
		wide_t nr, ni, er, ei, mag2, re, im;
		impedance_t res;
		bit sat;
		sat = 1'b0;
		br = $signed(it.br); bi = $signed(it.bi);
		cr = $signed(it.cr); ci = $signed(it.ci);
		zr = $signed(it.zr); zi = $signed(it.zi);
		if (it.op) begin
			pr = $signed(it.dr); pi = $signed(it.di);
			sr = $signed(it.ar); si = $signed(it.ai);
		end else begin
			pr = $signed(it.ar); pi = $signed(it.ai);
			sr = $signed(it.dr); si = $signed(it.di);
		end
		nr = pr * zr - pi * zi + (br <<< FB);
		ni = pr * zi + pi * zr + (bi <<< FB);
		er = cr * zr - ci * zi + (sr <<< FB);
		ei = cr * zi + ci * zr + (si <<< FB);
		mag2 = er * er + ei * ei;
		if (mag2 == 0) begin
			res.zre = '0;
			res.zim = '0;
			res.st = STATUS_DIV_ZERO;
			return res;
		end
		re = (nr * er + ni * ei) <<< FB;
		im = (ni * er - nr * ei) <<< FB;
		res.zre = rounded_quotient(re, mag2, sat);
		res.zim = rounded_quotient(im, mag2, sat);
		res.st = sat ? STATUS_SAT : STATUS_OK;
		return res;
	endfunction

	// Field values: full random words, modest Q16.16 values, or edge values.
	function automatic logic [DW-1:0] field_value(input int kind);
		case (kind)
			0: return DW'($urandom);
			1: return DW'(int'($urandom_range(0, 32'h000f_ffff)) - 32'sh0008_0000);
			default: begin
				case ($urandom_range(0, 6))
					0: return 32'h8000_0000;
					1: return 32'h7fff_ffff;
					2: return 32'h0001_0000;
					3: return 32'hffff_ffff;
					4: return 32'h0000_0001;
					5: return 32'hffff_0000;
					default: return '0;
				endcase
			end
		endcase
	endfunction

	function automatic network_item_t random_network(input int kind);
		network_item_t it;
		it.op = 1'($urandom);
		it.ar = field_value(kind); it.ai = field_value(kind);
		it.br = field_value(kind); it.bi = field_value(kind);
		it.cr = field_value(kind); it.ci = field_value(kind);
		it.dr = field_value(kind); it.di = field_value(kind);
		it.zr = field_value(kind); it.zi = field_value(kind);
		return it;
	endfunction

	function automatic network_item_t make_network(input logic op,
			input logic [DW-1:0] ar, ai, br, bi, cr, ci, dr, di, zr, zi);
		network_item_t it;
		it.op = op;
		it.ar = ar; it.ai = ai; it.br = br; it.bi = bi;
		it.cr = cr; it.ci = ci; it.dr = dr; it.di = di;
		it.zr = zr; it.zi = zi;
		return it;
	endfunction

	// The driver offers a new item whenever the previous one was taken or none
	// was on offer. Idling in the sender and receiver changes with the phase:
	// first the sender idles lightly and the receiver heavily, then the other
	// way round, then neither idles.
	always @(posedge clk or negedge arst_n) begin
		int send_idle;
		network_item_t it;
		if (!arst_n) begin
			item_valid <= 1'b0;
		end else begin
			send_idle = (sent_count < 450) ? 10 : (sent_count < 900) ? 64 : 0;
			if (item_valid && !item_stall) begin
				it.op = operation;
				it.ar = a_real; it.ai = a_imag; it.br = b_real; it.bi = b_imag;
				it.cr = c_real; it.ci = c_imag; it.dr = d_real; it.di = d_imag;
				it.zr = term_real; it.zi = term_imag;
				impedance_due.push_back(terminated_impedance(it));
				sent_count <= sent_count + 1;
			end
			if (!item_valid || !item_stall) begin
				if (pending_items.size() > 0 && $urandom_range(0, 99) >= send_idle) begin
					it = pending_items.pop_front();
					operation <= it.op;
					a_real <= it.ar; a_imag <= it.ai; b_real <= it.br; b_imag <= it.bi;
					c_real <= it.cr; c_imag <= it.ci; d_real <= it.dr; d_imag <= it.di;
					term_real <= it.zr; term_imag <= it.zi;
					item_valid <= 1'b1;
				end else begin
					item_valid <= 1'b0;
				end
			end
		end
	end

	// The receiver stalls at random by phase. Once, in the last phase, it holds
	// off for a long stretch so that the pipeline fills and the input stalls.
	always @(posedge clk or negedge arst_n) begin
		int recv_idle;
		if (!arst_n) begin
			result_stall <= 1'b0;
		end else begin
			recv_idle = (sent_count < 450) ? 64 : (sent_count < 900) ? 10 : 0;
			if (!hold_done && sent_count >= 1000) begin
				hold_done <= 1'b1;
				hold_cycles <= 3 * PIPE_DEPTH;
				result_stall <= 1'b1;
			end else if (hold_cycles > 0) begin
				hold_cycles <= hold_cycles - 1;
				result_stall <= 1'b1;
			end else begin
				result_stall <= ($urandom_range(0, 99) < recv_idle);
			end
		end
	end

	// Every accepted result is checked against the oldest expected impedance.
	always @(posedge clk) begin
		impedance_t exp_z;
		if (arst_n && result_valid && !result_stall) begin
			if (impedance_due.size() == 0) begin
				$display("%0t: result with nothing expected: re=%h im=%h status=%0d",
					$time, impedance_real, impedance_imag, status);
				failed = 1'b1;
			end else begin
				exp_z = impedance_due.pop_front();
				if (impedance_real !== exp_z.zre) begin
					$display("%0t: impedance_real expected %h actual %h",
						$time, exp_z.zre, impedance_real);
					failed = 1'b1;
				end
				if (impedance_imag !== exp_z.zim) begin
					$display("%0t: impedance_imag expected %h actual %h",
						$time, exp_z.zim, impedance_imag);
					failed = 1'b1;
				end
				if (status !== exp_z.st) begin
					$display("%0t: status expected %0d actual %0d",
						$time, exp_z.st, status);
					failed = 1'b1;
				end
			end
		end
	end

	initial begin
		int kind;
		// Directed items first.
		// An all-zero network has a zero denominator.
		pending_items.push_back(make_network(0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
		pending_items.push_back(make_network(1, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
		// A through connection: A = D = 1, B = C = 0, so C = 0 must work.
		pending_items.push_back(make_network(0, 32'h10000, 0, 0, 0, 0, 0,
			32'h10000, 0, 32'h320000, 32'hfff80000));
		pending_items.push_back(make_network(1, 32'h10000, 0, 0, 0, 0, 0,
			32'h10000, 0, 32'h320000, 32'h00080000));
		// A series impedance with a complex load.
		pending_items.push_back(make_network(0, 32'h10000, 0, 32'h50000, 32'h28000, 0, 0,
			32'h10000, 0, 32'h1c0000, 32'hfffd0000));
		// A shunt admittance with C nonzero.
		pending_items.push_back(make_network(1, 32'h10000, 0, 0, 0, 32'h00199a,
			32'hffffe000, 32'h10000, 0, 32'h320000, 0));
		// Denominator C*Z + D exactly zero while the numerator is not.
		pending_items.push_back(make_network(0, 32'h10000, 0, 32'h10000, 0, 32'h10000, 0,
			32'hffff0000, 0, 32'h10000, 0));
		// Denominator C*Z + A exactly zero for the output side.
		pending_items.push_back(make_network(1, 32'h20000, 0, 0, 32'h10000, 0, 32'h10000,
			32'h10000, 0, 0, 32'h20000));
		// A tiny denominator drives both parts into saturation.
		pending_items.push_back(make_network(0, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff,
			32'h80000000, 0, 0, 32'h00000001, 0, 32'h7fffffff, 32'h7fffffff));
		pending_items.push_back(make_network(1, 32'h00000001, 0, 32'h80000000,
			32'h80000000, 0, 0, 32'h80000000, 32'h80000000, 32'h80000000, 32'h80000000));
		// Halves to exercise rounding ties: B of 1 or 3 ulp in size, D = 2.
		pending_items.push_back(make_network(0, 0, 0, 32'h00000001, 32'hffffffff, 0, 0,
			32'h20000, 0, 0, 0));
		pending_items.push_back(make_network(0, 0, 0, 32'h00000003, 32'hfffffffd, 0, 0,
			32'h20000, 0, 0, 0));
		// All fields at their extremes, then all fields at -1 ulp.
		pending_items.push_back(make_network(0, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff,
			32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff,
			32'h7fffffff, 32'h7fffffff));
		pending_items.push_back(make_network(1, 32'h80000000, 32'h80000000, 32'h80000000,
			32'h80000000, 32'h80000000, 32'h80000000, 32'h80000000, 32'h80000000,
			32'h80000000, 32'h80000000));
		pending_items.push_back(make_network(0, 32'h80000000, 32'h7fffffff, 32'h80000000,
			32'h7fffffff, 32'h7fffffff, 32'h80000000, 32'h7fffffff, 32'h80000000,
			32'h80000000, 32'h7fffffff));
		pending_items.push_back(make_network(1, 32'hffffffff, 32'hffffffff, 32'hffffffff,
			32'hffffffff, 32'hffffffff, 32'hffffffff, 32'hffffffff, 32'hffffffff,
			32'hffffffff, 32'hffffffff));
		// Then random networks: mostly modest values, some full words and edges.
		for (int n = 0; n < N_RANDOM; n++) begin
			kind = $urandom_range(0, 9);
			kind = (kind < 6) ? 1 : (kind < 9) ? 0 : 2;
			pending_items.push_back(random_network(kind));
		end

		repeat (4) @(posedge clk);
		arst_n <= 1'b1;

		wait (pending_items.size() == 0);
		@(posedge clk);
		while (item_valid) @(posedge clk);
		wait (impedance_due.size() == 0);
		repeat (PIPE_DEPTH + 10) @(posedge clk);
		if (!failed)
			$display("tb_top: PASS");
		else
			$display("tb_top: FAIL");
		$finish;
	end

	initial begin
		#2ms;
		$display("tb_top: FAIL");
		$finish;
	end

endmodule
